// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

	// Default geometry of the character grid
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Position and address widths (positions cover COLUMNS up to 128, ROWS up to 64; addresses cover 2048 cells)
	localparam int COL_W  = 7;
	localparam int ROW_W  = 6;
	localparam int ADDR_W = 11;

	// Control characters and cell constants
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd1;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

	// Configuration register byte addresses
	localparam logic [2:0] REG_TEXT_COLOR = 3'd0;

	// Input word
	typedef struct packed {
		logic             mode;
		logic [7:0]       character;
		logic [COL_W-1:0] new_col;
		logic [4:0]       new_row;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic              cell_written;
		logic [ADDR_W-1:0] cell_address;
		logic [15:0]       cell_value;
		logic              screen_cleared;
		logic [ADDR_W-1:0] cursor_pos;
	} out_word_t;

	// Classified operation
	typedef enum logic [2:0] {
		OP_SETPOS,
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_PRINT
	} op_t;

	// Word passed from the front to the back through the queue
	typedef struct packed {
		op_t              op;
		logic [7:0]       character;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       color;
	} cmd_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_REPORT
	} back_state_t;

endpackage

// ===== rtl/core/tcw_front.sv =====
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tcw_pkg::in_word_t  cmd,
	input  logic [7:0]         text_color,
	input  tcw_pkg::q_status_t q_status,
	output logic               push,
	output tcw_pkg::cmd_t      push_cmd
);
	import tcw_pkg::*;

	localparam int CCMP_W = COL_W + 1;
	localparam int RCMP_W = ROW_W + 1;

	logic  valid_s1;
	cmd_t  item_s1;
	cmd_t  classed;
	logic  accept;

	// Stall only when the held word cannot enter the queue
	assign push   = valid_s1 && !q_status.full;
	assign busy   = valid_s1 && q_status.full;
	assign accept = start && !busy;
	assign push_cmd = item_s1;

	// Classify the incoming word and clamp the requested position
	always_comb begin
		classed.character = cmd.character;
		classed.color     = text_color;
		classed.col = (CCMP_W'(cmd.new_col) < CCMP_W'(COLUMNS)) ?
			cmd.new_col : COL_W'(COLUMNS - 1);
		classed.row = (RCMP_W'(cmd.new_row) < RCMP_W'(ROWS)) ?
			ROW_W'(cmd.new_row) : ROW_W'(ROWS - 1);
		if (cmd.mode) begin
			classed.op = OP_SETPOS;
		end else begin
			unique case (cmd.character)
				CH_NEWLINE:   classed.op = OP_NEWLINE;
				CH_RETURN:    classed.op = OP_RETURN;
				CH_BACKSPACE: classed.op = OP_BACKSPACE;
				default:      classed.op = OP_PRINT;
			endcase
		end
	end

	// Hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= classed;
		end
	end

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1)
		else $error("busy without a held word");
	a_set_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CCMP_W'(item_s1.col) < CCMP_W'(COLUMNS)))
		else $error("held column out of range");
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		$past(busy) && $past(valid_s1) |-> valid_s1)
		else $error("stalled word dropped");

endmodule

// ===== rtl/core/tcw_queue.sv =====
module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcw_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output tcw_pkg::cmd_t      pop_cmd,
	output tcw_pkg::q_status_t q_status
);
	import tcw_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_status.full  = (count_q == 2'd2);
	assign q_status.empty = (count_q == 2'd0);
	assign pop_cmd        = entry_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers disagree with fill count");

endmodule

// ===== rtl/core/tcw_back.sv =====
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::q_status_t q_status,
	output logic               pop,
	input  tcw_pkg::cmd_t      pop_cmd,
	output logic               done,
	output tcw_pkg::out_word_t result
);
	import tcw_pkg::*;

	localparam int CCMP_W = COL_W + 1;
	localparam int RCMP_W = ROW_W + 1;
	localparam int PROD_W = ROW_W + COL_W + 1;

	back_state_t       state_q, state_d;
	cmd_t              cmd_q;
	logic [COL_W-1:0]  wcol_q, ncol;
	logic [ROW_W-1:0]  wrow_q;
	logic [RCMP_W-1:0] nrow;
	logic [ADDR_W-1:0] shown_q, cursor;
	logic              wrote_q, cleared_q, wrote, clear;
	logic [ADDR_W-1:0] addr_q;
	logic [15:0]       value_q, value;
	logic [COL_W-1:0]  cell_col;
	logic [ROW_W-1:0]  cell_row;
	logic [PROD_W-1:0] cell_lin, cur_lin;
	logic              load_cmd, do_move, do_report;
	out_word_t         result_q;
	logic              done_q;

	assign result = result_q;
	assign done   = done_q;

	// Sequence: pick a word, move the position, report
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_cmd  = 1'b0;
		do_move   = 1'b0;
		do_report = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					pop      = 1'b1;
					load_cmd = 1'b1;
					state_d  = ST_MOVE;
				end
			end
			ST_MOVE: begin
				do_move = 1'b1;
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				do_report = 1'b1;
				if (!q_status.empty) begin
					pop      = 1'b1;
					load_cmd = 1'b1;
					state_d  = ST_MOVE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Next write position and the cell touched by this word
	always_comb begin
		ncol  = wcol_q;
		nrow  = RCMP_W'(wrow_q);
		wrote = 1'b0;
		value = {cmd_q.color, BLANK_CHAR};
		cell_col = wcol_q;
		cell_row = wrow_q;
		unique case (cmd_q.op)
			OP_SETPOS: begin
				ncol = cmd_q.col;
				nrow = RCMP_W'(cmd_q.row);
			end
			OP_NEWLINE: begin
				ncol = '0;
				nrow = RCMP_W'(wrow_q) + RCMP_W'(1);
			end
			OP_RETURN: begin
				ncol = '0;
			end
			OP_BACKSPACE: begin
				if (wcol_q != '0) begin
					ncol  = wcol_q - COL_W'(1);
					wrote = 1'b1;
				end else if (wrow_q != '0) begin
					ncol  = COL_W'(COLUMNS - 1);
					nrow  = RCMP_W'(wrow_q) - RCMP_W'(1);
					wrote = 1'b1;
				end
				cell_col = ncol;
				cell_row = ROW_W'(nrow);
			end
			OP_PRINT: begin
				wrote = 1'b1;
				value = {cmd_q.color, cmd_q.character};
				if (CCMP_W'(wcol_q) + CCMP_W'(1) >= CCMP_W'(COLUMNS)) begin
					ncol = '0;
					nrow = RCMP_W'(wrow_q) + RCMP_W'(1);
				end else begin
					ncol = wcol_q + COL_W'(1);
				end
			end
			default: ;
		endcase
		clear    = (cmd_q.op != OP_SETPOS) && (nrow >= RCMP_W'(ROWS));
		cell_lin = PROD_W'(cell_row) * PROD_W'(COLUMNS) + PROD_W'(cell_col);
		cur_lin  = PROD_W'(wrow_q) * PROD_W'(COLUMNS) + PROD_W'(wcol_q);
		cursor   = (cmd_q.op == OP_SETPOS) ? shown_q : cur_lin[ADDR_W-1:0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcol_q  <= '0;
			wrow_q  <= '0;
			shown_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= do_report;
			if (do_move) begin
				wcol_q <= clear ? '0 : ncol;
				wrow_q <= clear ? '0 : ROW_W'(nrow);
			end
			if (do_report) begin
				shown_q <= cursor;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= pop_cmd;
		end
		if (do_move) begin
			wrote_q   <= wrote;
			cleared_q <= clear;
			addr_q    <= wrote ? cell_lin[ADDR_W-1:0] : '0;
			value_q   <= wrote ? value : '0;
		end
		if (do_report) begin
			result_q.cell_written   <= wrote_q;
			result_q.cell_address   <= addr_q;
			result_q.cell_value     <= value_q;
			result_q.screen_cleared <= cleared_q;
			result_q.cursor_pos     <= cursor;
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.screen_cleared |-> result.cursor_pos == '0)
		else $error("clear without homed cursor");
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.cell_written |-> result.cell_address == '0 &&
		result.cell_value == '0)
		else $error("stale cell fields without a write");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		RCMP_W'(wrow_q) < RCMP_W'(ROWS))
		else $error("write row out of range");
	a_move_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> $past(load_cmd))
		else $error("move without a loaded word");

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Channel   Handshake                  Payload
// input     start / busy               cmd    (tcw_pkg::in_word_t)
// result    done (one-cycle strobe)    result (tcw_pkg::out_word_t)
// config    APB psel/penable/pwrite    text_color at byte address 0
//
// A word is classified in the front stage, queued (two entries), and executed by
// the back sequencer in its move and report states; the sequencer loads the next
// queued word while it reports the last one. The back sequencer's move/report pair
// sets the throughput. Screen clears are reported by a flag and add no state to the
// sequence. Reset homes the cursor and sets the color to white on black. The
// receiver cannot stall; busy rises only when the queue and the front stage are
// both full.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tcw_pkg::in_word_t  cmd,
	output logic               done,
	output tcw_pkg::out_word_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import tcw_pkg::*;

	logic      [7:0] text_color_q;
	logic            reg_sel;
	logic            push, pop;
	cmd_t            push_cmd, pop_cmd;
	q_status_t       q_status;

	// Decode the register file
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_TEXT_COLOR[2]);
	assign prdata  = reg_sel ? {24'd0, text_color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			text_color_q <= pwdata[7:0];
		end
	end

	tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.text_color (text_color_q),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.done     (done),
		.result   (result)
	);

endmodule
